### design/positional_point_list_unit_defines.svh
// assertion macros shared by the positional point list checker
`ifndef POSITIONAL_POINT_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_POINT_LIST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PPL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppl check failed");

// next-cycle implication, sampled on clk, off during rst
`define PPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppl check failed");

`endif

### design/ppl_pkg.sv
// types and constants of the positional point list
`timescale 1ns / 1ps
package ppl_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = 7;
  localparam int COORD_W  = 16;
  localparam int POINT_W  = 2 * COORD_W;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic        [POS_W-1:0]    position;
  } cmd_t;

  typedef struct packed {
    status_t                    status;
    logic signed [COORD_W-1:0]  found_x;
    logic signed [COORD_W-1:0]  found_y;
    logic        [POS_W-1:0]    entry_count;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               insert_go;
    logic               remove_go;
    logic               lookup_go;
    logic [CMP_W-1:0]   tail;
    logic [CMP_W-1:0]   pos_m1;
    logic [POINT_W-1:0] point;
  } cell_ctl_t;

endpackage

### design/ppl_cell.sv
// one storage cell of the point chain
`timescale 1ns / 1ps
module ppl_cell (
  input  logic                         clk,
  input  logic [ppl_pkg::IDX_W-1:0]    idx,
  input  ppl_pkg::cell_ctl_t           ctl,
  input  logic [ppl_pkg::POINT_W-1:0]  from_upper,
  output logic [ppl_pkg::POINT_W-1:0]  data,
  output logic [ppl_pkg::POINT_W-1:0]  hit_data
);
  import ppl_pkg::*;

  logic [CMP_W-1:0] idx_ext;
  logic             at_or_above;
  logic             at_tail;
  logic             at_pos;

  assign idx_ext     = CMP_W'(idx);
  assign at_or_above = (idx_ext >= ctl.pos_m1);
  assign at_tail     = (idx_ext == ctl.tail);
  assign at_pos      = (idx_ext == ctl.pos_m1);

  // take the upper neighbor on a remove, the new point on a tail insert
  always_ff @(posedge clk) begin
    if (ctl.remove_go && at_or_above) begin
      data <= from_upper;
    end else if (ctl.insert_go && at_tail) begin
      data <= ctl.point;
    end
  end

  assign hit_data = (ctl.lookup_go && at_pos) ? data : '0;

endmodule

### design/positional_point_list_unit.sv
// top level of the positional point list: control, cell chain, result register
// result: registered, valid in the cycle after its command transaction is accepted
// one command per cycle unless stalled; remove shifts cells >= pos at once
// a stalled result holds cmd_ready low until rsp_ready takes it
// reset (rst, synchronous, active high) empties the list and drops rsp_valid
// cell contents are not cleared; only cells below the count are ever read
`timescale 1ns / 1ps
module positional_point_list_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ppl_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ppl_pkg::rsp_t rsp
);
  import ppl_pkg::*;

  // number of stored points
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic               accept;
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   pos_ext;
  logic               pos_ok;
  logic               full;
  cell_ctl_t          ctl;
  status_t            status_next;
  logic [POINT_W-1:0] lookup_data;

  logic [POINT_W-1:0] cell_data [CAPACITY];
  logic [POINT_W-1:0] cell_hit  [CAPACITY];

  // the result register frees up when it is empty or being taken
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(cmd.position);
  // position is 1-based and must fall inside the stored range
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
  assign full      = (count_ext >= CMP_W'(CAPACITY));

  // broadcast to the chain; every go signal is qualified by accept
  always_comb begin
    ctl.insert_go = accept && (cmd.action == ACT_INSERT) && !full;
    ctl.remove_go = accept && (cmd.action == ACT_REMOVE) && pos_ok;
    ctl.lookup_go = accept && (cmd.action == ACT_LOOKUP) && pos_ok;
    ctl.tail      = count_ext;
    ctl.pos_m1    = pos_ext - CMP_W'(1);
    ctl.point     = {cmd.point_y, cmd.point_x};
  end

  // cell chain: each cell sees the cell above it, the top cell sees zero
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [POINT_W-1:0] upper;
    if (g == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_data[g+1];
    end
    ppl_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .ctl        (ctl),
      .from_upper (upper),
      .data       (cell_data[g]),
      .hit_data   (cell_hit[g])
    );
  end

  // at most one cell drives a nonzero hit, so an or gathers the lookup
  always_comb begin
    lookup_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lookup_data = lookup_data | cell_hit[i];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    unique case (cmd.action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!pos_ok) begin
          status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      ACT_LOOKUP: begin
        if (!pos_ok) begin
          status_next = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.found_x     <= lookup_data[COORD_W-1:0];
      rsp.found_y     <= lookup_data[POINT_W-1:COORD_W];
      rsp.entry_count <= POS_W'(count_next);
    end
  end

endmodule

### design/ppl_checker.sv
// port-level checks of the positional point list, bound to the top level
`timescale 1ns / 1ps
`include "positional_point_list_unit_defines.svh"
module ppl_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input ppl_pkg::cmd_t cmd,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ppl_pkg::rsp_t rsp
);
  import ppl_pkg::*;

  logic clear_taken;
  logic rsp_held;

  assign clear_taken = cmd_valid && cmd_ready && (cmd.action == ACT_CLEAR);
  assign rsp_held    = rsp_valid && !rsp_ready;

  // a stalled result stays
  `PPL_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp))
  // every accepted command yields a result next cycle
  `PPL_ASSERT_NEXT(a_cmd_to_rsp, cmd_valid && cmd_ready, rsp_valid)
  // a clear reports ok with an empty list
  `PPL_ASSERT_NEXT(a_clear_empty, clear_taken,
                   rsp.status == ST_OK && rsp.entry_count == '0)
  // coordinates are only returned on a good lookup
  `PPL_ASSERT_NOW(a_found_zero, rsp_valid && rsp.status != ST_OK,
                  rsp.found_x == '0 && rsp.found_y == '0)

endmodule

bind positional_point_list_unit ppl_checker u_ppl_checker (.*);

### tb/tb.sv
// testbench for the positional point list unit: directed and random actions checked per field
`timescale 1ns / 1ps
module tb;
  import ppl_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // chance in percent that a side idles on a given cycle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // shadow copy of the list: x in the low half of an entry, y in the high half
  logic [POINT_W-1:0] shadow_points [CAPACITY];
  int                 shadow_count;

  // replies still owed by the block, oldest first
  rsp_t awaited_rsp [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;

  positional_point_list_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard: a stuck handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // apply one action to the shadow list and return the reply it calls for
  function automatic rsp_t apply_action(input cmd_t c);
    rsp_t r;
    int   p;
    bit   in_range;
    r = '0;
    r.status = ST_OK;
    p = c.position;
    in_range = (p >= 1) && (p <= shadow_count) && (p <= CAPACITY);
    case (c.action)
      ACT_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_points[shadow_count] = {c.point_y, c.point_x};
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        if (!in_range) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap: every later point moves down one place
          for (int i = p - 1; i + 1 < shadow_count; i++)
            shadow_points[i] = shadow_points[i + 1];
          shadow_count--;
        end
      end
      ACT_LOOKUP: begin
        if (!in_range) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_x = shadow_points[p - 1][COORD_W-1:0];
          r.found_y = shadow_points[p - 1][POINT_W-1:COORD_W];
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    r.entry_count = POS_W'(shadow_count);
    return r;
  endfunction

  // one command transaction: optional idle gap, then hold valid until accepted
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    awaited_rsp.push_back(apply_action(c));
  endtask

  task automatic send_action(input action_t a, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y, input int pos);
    cmd_t c;
    c.action   = a;
    c.point_x  = x;
    c.point_y  = y;
    c.position = POS_W'(pos);
    send_cmd(c);
  endtask

  // mostly random coordinates, with the extremes showing up often
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(15))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      3:       return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("rsp: result transaction with no command waiting");
        mismatch_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.found_x !== want.found_x) begin
          $error("found_x: expected %0d, got %0d", want.found_x, rsp.found_x);
          mismatch_count++;
        end
        if (rsp.found_y !== want.found_y) begin
          $error("found_y: expected %0d, got %0d", want.found_y, rsp.found_y);
          mismatch_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // empty list after reset: every position is missing
  task automatic test_empty_store();
    send_action(ACT_LOOKUP, 16'sd1, 16'sd2, 1);
    send_action(ACT_REMOVE, 16'sd3, 16'sd4, 1);
    send_action(ACT_LOOKUP, 16'sd5, 16'sd6, 0);
  endtask

  // sign patterns at both ends of the coordinate range
  task automatic test_insert_extremes();
    send_action(ACT_INSERT, -16'sd32768, 16'sd32767, 0);
    send_action(ACT_INSERT, 16'sd32767, -16'sd32768, 127);
    send_action(ACT_INSERT, 16'sd0, 16'sd0, 64);
    send_action(ACT_INSERT, -16'sd1, -16'sd1, 1);
    send_action(ACT_INSERT, 16'sh5555, -16'sh5556, 42);
  endtask

  // lookup inside the list, at position zero and past the count
  task automatic test_lookup_positions();
    send_action(ACT_LOOKUP, '0, '0, 1);
    send_action(ACT_LOOKUP, -16'sd1, -16'sd1, 5);
    send_action(ACT_LOOKUP, '0, '0, 0);
    send_action(ACT_LOOKUP, '0, '0, 6);
    send_action(ACT_LOOKUP, '0, '0, 127);
    send_action(ACT_LOOKUP, '0, '0, 4);
  endtask

  // remove in the middle, at the tail and at the head, then bad positions
  task automatic test_remove_shift();
    send_action(ACT_REMOVE, '0, '0, 2);
    send_action(ACT_LOOKUP, '0, '0, 2);
    send_action(ACT_REMOVE, '0, '0, 4);
    send_action(ACT_REMOVE, '0, '0, 1);
    send_action(ACT_REMOVE, '0, '0, 0);
    send_action(ACT_LOOKUP, '0, '0, 3);
  endtask

  // clear drops the count; old points must not come back
  task automatic test_clear_store();
    send_action(ACT_CLEAR, 16'sd7, 16'sd8, 1);
    send_action(ACT_LOOKUP, '0, '0, 1);
    send_action(ACT_INSERT, 16'sd100, -16'sd100, 0);
  endtask

  // random actions, positions mostly inside the list
  task automatic test_random_mix(input int n);
    cmd_t c;
    int   roll;
    for (int k = 0; k < n; k++) begin
      c.point_x = rand_coord();
      c.point_y = rand_coord();
      roll = $urandom_range(99);
      if (roll < 42)      c.action = ACT_INSERT;
      else if (roll < 67) c.action = ACT_REMOVE;
      else if (roll < 98) c.action = ACT_LOOKUP;
      else                c.action = ACT_CLEAR;
      if (shadow_count > 0 && $urandom_range(99) < 80)
        c.position = POS_W'($urandom_range(shadow_count, 1));
      else
        c.position = POS_W'($urandom_range(127));
      send_cmd(c);
    end
  endtask

  // fill to capacity, push past it, then touch the last slot and beyond
  task automatic test_fill_to_capacity();
    int extra;
    extra = $urandom_range(3, 1);
    while (shadow_count < CAPACITY)
      send_action(ACT_INSERT, rand_coord(), rand_coord(), $urandom_range(127));
    repeat (extra) send_action(ACT_INSERT, rand_coord(), rand_coord(), $urandom_range(127));
    send_action(ACT_LOOKUP, '0, '0, CAPACITY);
    send_action(ACT_LOOKUP, '0, '0, CAPACITY + 1);
    send_action(ACT_REMOVE, '0, '0, $urandom_range(CAPACITY, 1));
    send_action(ACT_INSERT, rand_coord(), rand_coord(), 0);
    send_action(ACT_INSERT, rand_coord(), rand_coord(), 0);
  endtask

  task automatic run_random_phase();
    test_random_mix(120);
    test_fill_to_capacity();
    test_random_mix(70);
  endtask

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    rsp_ready    = 1'b0;
    shadow_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, no idling
    test_empty_store();
    test_insert_extremes();
    test_lookup_positions();
    test_remove_shift();
    test_clear_store();

    // sender idles less than the receiver
    send_idle_pct = 32;
    recv_idle_pct = 61;
    run_random_phase();

    // receiver idles less than the sender
    send_idle_pct = 61;
    recv_idle_pct = 32;
    run_random_phase();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase();

    @(negedge clk);
    cmd_valid <= 1'b0;

    // wait for every owed result, then drain for stray ones
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
